// File: rtl/core/utf8_acute_nfc_composer_core_defines.svh
// Assertion macros shared by the composer's checker.
`ifndef UTF8_ACUTE_NFC_COMPOSER_CORE_DEFINES_SVH
`define UTF8_ACUTE_NFC_COMPOSER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define UANC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uanc check failed");

// Next-cycle implication, off while reset is asserted.
`define UANC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uanc check failed");

`endif

// File: rtl/core/uanc_pkg.sv
package uanc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    localparam logic [7:0] ACCENT_LEAD = 8'hCC;
    localparam logic [5:0] ACCENT_LOW  = 6'h01;

    // At most three bytes come out of one item.
    localparam int RESULT_MAX  = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        message_done;
        logic        overflow_error;
        logic [15:0] total_length;
    } result_t;

    typedef struct packed {
        logic [1:0]                     count;
        result_t [RESULT_MAX-1:0]       rec;
    } push_t;

    // Precomposed code point of a vowel with acute; zero for anything else.
    function automatic logic [7:0] accented_code(input logic [6:0] c);
        logic [7:0] code;
        case (c)
            7'h61:   code = 8'hE1; // a
            7'h41:   code = 8'hC1; // A
            7'h65:   code = 8'hE9; // e
            7'h45:   code = 8'hC9; // E
            7'h69:   code = 8'hED; // i
            7'h49:   code = 8'hCD; // I
            7'h6F:   code = 8'hF3; // o
            7'h4F:   code = 8'hD3; // O
            7'h75:   code = 8'hFA; // u
            7'h55:   code = 8'hDA; // U
            7'h79:   code = 8'hFD; // y
            7'h59:   code = 8'hDD; // Y
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    // Number of continuation bytes announced by a lead byte.
    function automatic logic [1:0] lead_class(input logic [7:0] b);
        logic [1:0] n;
        if (b[7:5] == 3'b110) begin
            n = 2'd1;
        end
        else if (b[7:4] == 4'b1110) begin
            n = 2'd2;
        end
        else if (b[7:3] == 5'b11110) begin
            n = 2'd3;
        end
        else begin
            n = 2'd0;
        end
        return n;
    endfunction

endpackage

// File: rtl/core/uanc_step.sv
module uanc_step
    import uanc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  in_byte,
    input  logic        end_of_message,
    input  logic [15:0] capacity,
    output push_t       push
);

    localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [6:0]             held_letter_reg, held_letter_next;
    logic                   letter_pending_reg, letter_pending_next;
    logic                   mark_pending_reg, mark_pending_next;
    logic [1:0]             cont_left_reg, cont_left_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   ovf_reg, ovf_next;

    logic [7:0]             cand [RESULT_MAX];
    logic [1:0]             n_cand;
    logic [7:0]             code;
    logic [LW-1:0]          cap_ext, max_ext, lim_ext, total_ext;
    logic [COUNT_WIDTH-1:0] limit, room, count_after;
    logic [1:0]             emitted, nres;
    logic                   ovf_after;

    // Candidate bytes and the new letter/sequence state.
    always_comb
    begin
        for (int k = 0; k < RESULT_MAX; k++)
        begin
            cand[k] = 8'h00;
        end
        n_cand              = 2'd0;
        held_letter_next    = held_letter_reg;
        letter_pending_next = letter_pending_reg;
        mark_pending_next   = mark_pending_reg;
        cont_left_next      = cont_left_reg;
        code                = accented_code(held_letter_reg);

        if (mark_pending_reg)
        begin
            if (in_byte[5:0] == ACCENT_LOW)
            begin
                cand[0] = {6'b110000, code[7:6]};
                cand[1] = {2'b10, code[5:0]};
                n_cand  = 2'd2;
            end
            else
            begin
                cand[0] = {1'b0, held_letter_reg};
                cand[1] = ACCENT_LEAD;
                cand[2] = in_byte;
                n_cand  = 2'd3;
            end
            letter_pending_next = 1'b0;
            mark_pending_next   = 1'b0;
            cont_left_next      = 2'd0;
        end
        else if (cont_left_reg != 2'd0)
        begin
            cand[0]        = in_byte;
            n_cand         = 2'd1;
            cont_left_next = cont_left_reg - 2'd1;
        end
        else if (letter_pending_reg && in_byte == ACCENT_LEAD)
        begin
            mark_pending_next = 1'b1;
        end
        else
        begin
            if (letter_pending_reg)
            begin
                cand[n_cand]        = {1'b0, held_letter_reg};
                n_cand              = n_cand + 2'd1;
                letter_pending_next = 1'b0;
            end
            if (!in_byte[7] && accented_code(in_byte[6:0]) != 8'h00)
            begin
                held_letter_next    = in_byte[6:0];
                letter_pending_next = 1'b1;
            end
            else
            begin
                cand[n_cand]   = in_byte;
                n_cand         = n_cand + 2'd1;
                cont_left_next = lead_class(in_byte);
            end
        end

        // Flush whatever is held at the end of the message.
        if (end_of_message)
        begin
            if (letter_pending_next)
            begin
                cand[n_cand] = {1'b0, held_letter_next};
                n_cand       = n_cand + 2'd1;
            end
            if (mark_pending_next)
            begin
                cand[n_cand] = ACCENT_LEAD;
                n_cand       = n_cand + 2'd1;
            end
            letter_pending_next = 1'b0;
            mark_pending_next   = 1'b0;
        end
    end

    // Capacity check: emit what fits, flag the first byte that does not.
    always_comb
    begin
        cap_ext = LW'(capacity);
        max_ext = LW'({COUNT_WIDTH{1'b1}});
        lim_ext = (cap_ext < max_ext) ? cap_ext : max_ext;
        limit   = lim_ext[COUNT_WIDTH-1:0];
        room    = (count_reg >= limit) ? '0 : (limit - count_reg);

        if (ovf_reg)
        begin
            emitted   = 2'd0;
            ovf_after = 1'b1;
        end
        else if (room < COUNT_WIDTH'(n_cand))
        begin
            emitted   = room[1:0];
            ovf_after = 1'b1;
        end
        else
        begin
            emitted   = n_cand;
            ovf_after = 1'b0;
        end

        count_after = count_reg + COUNT_WIDTH'(emitted);
        total_ext   = LW'(count_after);
        nres        = (end_of_message && emitted == 2'd0) ? 2'd1 : emitted;
    end

    // Build the result records.
    always_comb
    begin
        push.count = nres;
        for (int k = 0; k < RESULT_MAX; k++)
        begin
            push.rec[k].out_byte       = (2'(k) < emitted) ? cand[k] : 8'h00;
            push.rec[k].byte_valid     = (2'(k) < emitted);
            push.rec[k].run_last       = (2'(k) == nres - 2'd1);
            push.rec[k].message_done   = end_of_message && (2'(k) == nres - 2'd1);
            push.rec[k].overflow_error = ovf_after;
            push.rec[k].total_length   =
                (end_of_message && (2'(k) == nres - 2'd1) && !ovf_after)
                ? total_ext[15:0] : 16'h0000;
        end
    end

    always_comb
    begin
        count_next = end_of_message ? '0 : count_after;
        ovf_next   = end_of_message ? 1'b0 : ovf_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg    <= 7'd0;
            letter_pending_reg <= 1'b0;
            mark_pending_reg   <= 1'b0;
            cont_left_reg      <= 2'd0;
            count_reg          <= '0;
            ovf_reg            <= 1'b0;
        end
        else if (accept)
        begin
            held_letter_reg    <= end_of_message ? 7'd0 : held_letter_next;
            letter_pending_reg <= letter_pending_next;
            mark_pending_reg   <= mark_pending_next;
            cont_left_reg      <= end_of_message ? 2'd0 : cont_left_next;
            count_reg          <= count_next;
            ovf_reg            <= ovf_next;
        end
    end

endmodule

// File: rtl/core/uanc_queue.sv
module uanc_queue
    import uanc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_en,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t head
);

    result_t              entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [1:0]           push_n;
    logic                 pop;

    // Room for a full burst, judged on the registered level only.
    assign space_ok  = (level_reg <= LEVEL_W'(QUEUE_DEPTH - RESULT_MAX));
    assign out_valid = (level_reg != '0);
    assign head      = entry[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign push_n    = push_en ? push.count : 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LEVEL_W'(push_n) - LEVEL_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < RESULT_MAX; k++)
        begin
            if (2'(k) < push_n)
            begin
                entry[wr_ptr_reg + PTR_W'(k)] <= push.rec[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// File: rtl/core/utf8_acute_nfc_composer_core.sv
// Streaming acute-accent composer for UTF-8 messages.
// Input channel: in_valid / in_stall carry one byte (in_byte) and its end_of_message
// mark; an item is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result item per handshake: out_byte,
// byte_valid, run_last, message_done, overflow_error and total_length.
// Each input item causes zero to three result items. A vowel, then 0xCC and a byte
// with low six bits 0x01 (as in U+0301), comes out precomposed; all else is copied.
// The final byte of a message always causes at least one item, the last of which
// carries message_done. An item's results enter the result queue when it is taken.
// Throughput: one input item per cycle while each item yields at most one result and
// the receiver does not stall; two or three results of one item need a handshake each.
// The four-entry result queue sets this: in_stall rises when over one entry is held.
// A receiver stall holds the head item steady and fills the queue until in_stall rises.
// Configuration: cfg_write loads cfg_data into the output capacity; write only when
// idle. Reset clears message state and the queue and sets the capacity to 65535.
module utf8_acute_nfc_composer_core
    import uanc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        run_last,
    output logic        message_done,
    output logic        overflow_error,
    output logic [15:0] total_length
);

    logic [15:0] capacity_reg;
    logic        accept;
    logic        space_ok;
    push_t       push;
    result_t     head;

    // Take a new item only when the queue can absorb a full burst.
    assign in_stall = !space_ok;
    assign accept   = in_valid && space_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // Decode, compose and count in one pass per item.
    uanc_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .capacity       (capacity_reg),
        .push           (push)
    );

    // Hold results until the receiver takes them.
    uanc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign out_byte       = head.out_byte;
    assign byte_valid     = head.byte_valid;
    assign run_last       = head.run_last;
    assign message_done   = head.message_done;
    assign overflow_error = head.overflow_error;
    assign total_length   = head.total_length;

endmodule

// File: rtl/core/uanc_checker.sv
`include "utf8_acute_nfc_composer_core_defines.svh"

module uanc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        run_last,
    input logic        message_done,
    input logic        overflow_error,
    input logic [15:0] total_length
);

    // A stalled result holds.
    `UANC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last) && $stable(message_done))

    // The end of a message always closes the item's run.
    `UANC_ASSERT_NOW(a_done_is_last, clk, rst_n, out_valid && message_done, run_last)

    // An empty result only stands for the final byte of a message.
    `UANC_ASSERT_NOW(a_empty_only_at_end, clk, rst_n, out_valid && !byte_valid, message_done && out_byte == 8'h00)

    // A length is reported only on a clean message end.
    `UANC_ASSERT_NOW(a_length_at_end, clk, rst_n, out_valid && total_length != 16'h0000, message_done && !overflow_error)

endmodule

bind utf8_acute_nfc_composer_core uanc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .run_last       (run_last),
    .message_done   (message_done),
    .overflow_error (overflow_error),
    .total_length   (total_length)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import uanc_pkg::*;

    // One byte of a message as the sender presents it.
    typedef struct {
        logic [7:0] data;
        bit         last;
    } msg_byte_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write      = 1'b0;
    logic [15:0] cfg_data       = 16'h0000;
    logic        in_valid       = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte        = 8'h00;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall      = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        message_done;
    logic        overflow_error;
    logic [15:0] total_length;

    utf8_acute_nfc_composer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .run_last       (run_last),
        .message_done   (message_done),
        .overflow_error (overflow_error),
        .total_length   (total_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes waiting for the driver, and composed output bytes waiting for the monitor.
    msg_byte_t   send_q[$];
    result_t     composed_due[$];
    int unsigned bytes_queued = 0;
    int unsigned mismatches   = 0;

    // Shadow of the composer: capacity register plus per-message state.
    logic [15:0] capacity_shadow = CAPACITY_RESET;
    logic [6:0]  held_vowel      = '0;
    bit          vowel_held      = 1'b0;
    bit          lead_held       = 1'b0;
    logic [1:0]  cont_left       = '0;
    int unsigned emitted_count   = 0;
    bit          over_cap        = 1'b0;
    logic [7:0]  staged[3];
    int          staged_n;

    // Precomposed code of a vowel with acute accent; zero for any other character.
    // Capitals sit 0x20 below their lowercase forms, as in Latin-1.
    function automatic logic [7:0] acute_code(input logic [6:0] ch);
        logic [7:0] lower_code;
        case (ch | 7'h20)
            7'h61:   lower_code = 8'hE1;  // a
            7'h65:   lower_code = 8'hE9;  // e
            7'h69:   lower_code = 8'hED;  // i
            7'h6F:   lower_code = 8'hF3;  // o
            7'h75:   lower_code = 8'hFA;  // u
            7'h79:   lower_code = 8'hFD;  // y
            default: lower_code = 8'h00;
        endcase
        if (lower_code != 8'h00 && !ch[5])
        begin
            lower_code = lower_code - 8'h20;
        end
        return lower_code;
    endfunction

    // Stage one output byte unless the capacity is already used up; the first byte
    // past the limit sets the sticky overflow flag and every later byte is dropped.
    function automatic void emit_byte(input logic [7:0] b);
        if (over_cap)
        begin
            return;
        end
        if (emitted_count >= capacity_shadow)
        begin
            over_cap = 1'b1;
            return;
        end
        if (staged_n < 3)
        begin
            staged[staged_n] = b;
            staged_n++;
        end
        emitted_count++;
    endfunction

    // Advance the shadow by one accepted item and append the output items it causes.
    function automatic void compose_item(input logic [7:0] b, input bit last);
        logic [7:0] code;
        result_t    res[3];
        int         n;
        staged_n = 0;
        if (lead_held)
        begin
            // Vowel and 0xCC are held: the third byte decides composed or copied.
            if (b[5:0] == ACCENT_LOW)
            begin
                code = acute_code(held_vowel);
                emit_byte(8'hC0 | (code >> 6));
                emit_byte(8'h80 | {2'b00, code[5:0]});
            end
            else
            begin
                emit_byte({1'b0, held_vowel});
                emit_byte(ACCENT_LEAD);
                emit_byte(b);
            end
            vowel_held = 1'b0;
            lead_held  = 1'b0;
            cont_left  = 2'd0;
        end
        else if (cont_left != 2'd0)
        begin
            // Continuation bytes are copied and never start a candidate.
            emit_byte(b);
            cont_left = cont_left - 2'd1;
        end
        else if (vowel_held && b == ACCENT_LEAD)
        begin
            lead_held = 1'b1;
        end
        else
        begin
            if (vowel_held)
            begin
                emit_byte({1'b0, held_vowel});
                vowel_held = 1'b0;
            end
            if (!b[7] && acute_code(b[6:0]) != 8'h00)
            begin
                held_vowel = b[6:0];
                vowel_held = 1'b1;
            end
            else
            begin
                emit_byte(b);
                casez (b)
                    8'b110?????: cont_left = 2'd1;
                    8'b1110????: cont_left = 2'd2;
                    8'b11110???: cont_left = 2'd3;
                    default:     cont_left = 2'd0;
                endcase
            end
        end

        // End of message flushes whatever is still held, unchanged.
        if (last)
        begin
            if (vowel_held)
            begin
                emit_byte({1'b0, held_vowel});
            end
            if (lead_held)
            begin
                emit_byte(ACCENT_LEAD);
            end
            vowel_held = 1'b0;
            lead_held  = 1'b0;
        end

        n = staged_n;
        for (int k = 0; k < 3; k++)
        begin
            res[k] = '0;
            if (k < staged_n)
            begin
                res[k].out_byte       = staged[k];
                res[k].byte_valid     = 1'b1;
                res[k].overflow_error = over_cap;
            end
        end
        // A final byte that emits nothing still reports the message end.
        if (last && n == 0)
        begin
            res[0].overflow_error = over_cap;
            n = 1;
        end
        if (n > 0)
        begin
            res[n-1].run_last = 1'b1;
            if (last)
            begin
                res[n-1].message_done = 1'b1;
                res[n-1].total_length = over_cap ? 16'h0000 : emitted_count[15:0];
            end
        end
        for (int k = 0; k < n; k++)
        begin
            composed_due.push_back(res[k]);
        end

        if (last)
        begin
            held_vowel    = '0;
            cont_left     = 2'd0;
            emitted_count = 0;
            over_cap      = 1'b0;
        end
    endfunction

    task automatic check_field(input string field, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0h, got %0h", field, want_v, got_v);
            mismatches++;
        end
    endtask

    // Driver: send bursts of random length separated by random gaps. Predict each
    // item on the edge that accepts it, and hold the payload while stalled.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin : driver_proc
        bit busy;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            in_byte        <= 8'h00;
            end_of_message <= 1'b0;
        end
        else
        begin
            busy = in_valid && in_stall;
            if (in_valid && !in_stall)
            begin
                compose_item(in_byte, end_of_message);
            end
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (send_q.size() > 0)
                begin
                    in_valid       <= 1'b1;
                    in_byte        <= send_q[0].data;
                    end_of_message <= send_q[0].last;
                    void'(send_q.pop_front());
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        // A quarter of the bursts run straight into the next one.
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted output item with the oldest prediction, and
    // stall on a pattern that switches between free flow, light, heavy and toggling.
    int stall_mode   = 0;
    int stretch_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (composed_due.size() == 0)
                begin
                    $error("output item with nothing predicted: out_byte %0h", out_byte);
                    mismatches++;
                end
                else
                begin
                    want = composed_due.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
                    check_field("byte_valid", 16'(want.byte_valid), 16'(byte_valid));
                    check_field("run_last", 16'(want.run_last), 16'(run_last));
                    check_field("message_done", 16'(want.message_done),
                                16'(message_done));
                    check_field("overflow_error", 16'(want.overflow_error),
                                16'(overflow_error));
                    check_field("total_length", want.total_length, total_length);
                end
            end
            if (stretch_left == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                stretch_left = $urandom_range(5, 40);
            end
            else
            begin
                stretch_left--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= !out_stall;
            endcase
        end
    end

    task automatic queue_byte(input logic [7:0] b, input bit last);
        msg_byte_t item;
        item.data = b;
        item.last = last;
        send_q.push_back(item);
        bytes_queued++;
    endtask

    function automatic logic [7:0] random_vowel();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0:       v = "a";
            1:       v = "e";
            2:       v = "i";
            3:       v = "o";
            4:       v = "u";
            default: v = "y";
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            v[5] = 1'b0;
        end
        return v;
    endfunction

    // Build one message from tokens: mostly vowels with a combining acute and valid
    // multi-byte sequences, plus broken accents, cut sequences and raw noise.
    task automatic queue_random_message();
        logic [7:0] msg[$];
        logic [7:0] v;
        int         kind;
        int         len;
        repeat ($urandom_range(1, 7))
        begin
            kind = $urandom_range(0, 99);
            v    = 8'($urandom);
            if (kind < 30)
            begin
                msg.push_back(random_vowel());
                msg.push_back(ACCENT_LEAD);
                case ($urandom_range(0, 4))
                    0, 1:    msg.push_back(8'h81);
                    2:       msg.push_back({v[7:6], ACCENT_LOW});
                    default: msg.push_back(v);
                endcase
            end
            else if (kind < 45)
            begin
                msg.push_back(random_vowel());
            end
            else if (kind < 60)
            begin
                msg.push_back({1'b0, v[6:0]});
            end
            else if (kind < 78)
            begin
                len = $urandom_range(1, 3);
                case (len)
                    1:       msg.push_back({3'b110, v[4:0]});
                    2:       msg.push_back({4'b1110, v[3:0]});
                    default: msg.push_back({5'b11110, v[2:0]});
                endcase
                // Cut the sequence short now and then.
                if ($urandom_range(0, 7) == 0)
                begin
                    len = $urandom_range(0, len - 1);
                end
                for (int k = 0; k < len; k++)
                begin
                    v = 8'($urandom);
                    msg.push_back(($urandom_range(0, 5) == 0) ? v : {2'b10, v[5:0]});
                end
            end
            else if (kind < 86)
            begin
                // Vowel and accent lead left for the next token or the message end.
                msg.push_back(random_vowel());
                msg.push_back(ACCENT_LEAD);
            end
            else
            begin
                msg.push_back(v);
            end
        end
        foreach (msg[k])
        begin
            queue_byte(msg[k], k == msg.size() - 1);
        end
    endtask

    // Pause the sender until every queued item is taken and every prediction has
    // been matched, then let the pipeline settle.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (send_q.size() != 0 || in_valid || composed_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        capacity_shadow = value;
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [15:0] capacity, input int unsigned n_bytes);
        int unsigned target;
        write_capacity(capacity);
        target = bytes_queued + n_bytes;
        while (bytes_queued < target)
        begin
            queue_random_message();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: composed accent, accent with unchecked marker bits.
        queue_byte("a", 1'b0);
        queue_byte(ACCENT_LEAD, 1'b0);
        queue_byte(8'h81, 1'b0);
        queue_byte("Y", 1'b0);
        queue_byte(ACCENT_LEAD, 1'b0);
        queue_byte(8'h01, 1'b1);
        // Accent mismatch: three bytes from one item, then a zero byte to end.
        queue_byte("e", 1'b0);
        queue_byte(ACCENT_LEAD, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'h00, 1'b1);
        // Held vowel flushed at the message end.
        queue_byte("o", 1'b1);
        // Held vowel and accent lead flushed at the message end.
        queue_byte("U", 1'b0);
        queue_byte(ACCENT_LEAD, 1'b1);
        // Vowels inside multi-byte sequences stay as they are; a bare 0xCC is a lead.
        queue_byte(8'hC3, 1'b0);
        queue_byte("a", 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h9F, 1'b0);
        queue_byte(8'h98, 1'b0);
        queue_byte("i", 1'b0);
        queue_byte(ACCENT_LEAD, 1'b0);
        queue_byte("a", 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_drained();

        // Random phases across capacity settings, extremes included.
        run_phase(16'hFFFF, 80);
        run_phase(16'd1, 40);
        run_phase(16'd0, 30);
        run_phase(16'd5, 60);
        run_phase(16'($urandom_range(2, 40)), 90);
        run_phase(16'hFFFF, 105);

        repeat (10) @(posedge clk);
        if (mismatches == 0 && composed_due.size() == 0)
        begin
            $display("utf8_acute_nfc_composer_core regression: pass");
        end
        else
        begin
            $display("utf8_acute_nfc_composer_core regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #3000000;
        $display("utf8_acute_nfc_composer_core regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/uanc_pkg.sv
rtl/core/uanc_step.sv
rtl/core/uanc_queue.sv
rtl/core/utf8_acute_nfc_composer_core.sv
rtl/core/uanc_checker.sv
sim/testbench.sv
